### hdl/ped_pkg.sv
// ped_pkg: shared constants, types and digit helpers for the percent-escape decoder.
// No dependencies; compile first.
package ped_pkg;

  localparam logic [7:0] PctChar    = 8'h25;
  localparam logic [7:0] UpperOfs   = 8'h07;
  localparam logic [7:0] LowerOfs   = 8'h27;
  localparam logic [7:0] DigitBase  = 8'h30;
  localparam logic [7:0] PrintFirst = 8'h32;
  localparam logic [7:0] NineChar   = 8'h39;

  // output queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);
  localparam int unsigned MaxRes    = 3;
  localparam logic [FifoCw-1:0] AcceptLimit = FifoCw'(FifoDepth - MaxRes);

  typedef enum logic [1:0] {
    PendIdle,
    PendPct,
    PendDigit
  } pend_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_of_run;
    logic       line_done;
  } res_t;

  function automatic logic is_letter_digit(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic is_first_digit(input logic [7:0] c, input logic printable);
    logic [7:0] lo;
    lo = printable ? PrintFirst : DigitBase;
    return (c >= lo && c <= NineChar) || is_letter_digit(c);
  endfunction

  function automatic logic is_any_digit(input logic [7:0] c);
    return (c >= DigitBase && c <= NineChar) || is_letter_digit(c);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    logic [7:0] d;
    v = c;
    if (c >= 8'h41 && c <= 8'h46) begin
      v = c - UpperOfs;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - LowerOfs;
    end
    d = v - DigitBase;
    return d[3:0];
  endfunction

endpackage

### hdl/ped_if.sv
// ped_if: valid/ready channel interfaces for input bytes, results and configuration.
// Plain signal bundles; no package dependency.
interface ped_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_line;
  modport source (output valid, output byte_in, output end_of_line, input ready);
  modport sink   (input valid, input byte_in, input end_of_line, output ready);
endinterface

interface ped_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_of_run;
  logic       line_done;
  modport source (output valid, output byte_out, output last_of_run, output line_done,
                  input ready);
  modport sink   (input valid, input byte_out, input last_of_run, input line_done,
                  output ready);
endinterface

interface ped_cfg_if;
  logic valid;
  logic ready;
  logic printable_only;
  modport source (output valid, output printable_only, input ready);
  modport sink   (input valid, input printable_only, output ready);
endinterface

### hdl/percent_escape_decoder.sv
// Results of a byte are written into the output queue on its transfer and leave it behind earlier results.
// Throughput: one byte per cycle; the output queue (8 entries) drains one result per cycle while
// out_o.ready is high, and input is held off only while fewer than three slots are free.
// Each byte yields 0 to 3 results, decided in one pass from the escape state, printable_only and the byte.
// Reset (rst_ni low, asynchronous) empties the queue, clears the escape state and
// sets printable_only to 0.
module percent_escape_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ped_cfg_if.sink   cfg_i,
  ped_in_if.sink    in_i,
  ped_out_if.source out_o
);
  import ped_pkg::*;

  logic              printable_q;
  pend_e             pend_q, pend_d;
  logic [7:0]        held_q, held_d;

  res_t              fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, rd_q;
  logic [FifoCw-1:0] count_q, count_d;

  res_t              res_c [MaxRes];
  logic [1:0]        n_c;
  logic              fresh;
  logic              in_xfer, out_xfer;
  logic [FifoAw-1:0] widx [MaxRes];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (count_q <= AcceptLimit);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_o.valid && out_o.ready;

  always_comb begin
    pend_d = pend_q;
    held_d = held_q;
    n_c    = 2'd0;
    fresh  = 1'b0;
    for (int k = 0; k < MaxRes; k++) begin
      res_c[k] = '0;
    end
    case (pend_q)
      PendPct: begin
        if (is_first_digit(in_i.byte_in, printable_q)) begin
          if (in_i.end_of_line) begin
            res_c[0].byte_out = PctChar;
            res_c[1].byte_out = in_i.byte_in;
            n_c = 2'd2;
          end else begin
            held_d = in_i.byte_in;
            pend_d = PendDigit;
          end
        end else begin
          res_c[0].byte_out = PctChar;
          n_c   = 2'd1;
          fresh = 1'b1;
        end
      end
      PendDigit: begin
        if (is_any_digit(in_i.byte_in)) begin
          res_c[0].byte_out = {digit_value(held_q), digit_value(in_i.byte_in)};
          n_c    = 2'd1;
          pend_d = PendIdle;
        end else begin
          res_c[0].byte_out = PctChar;
          res_c[1].byte_out = held_q;
          n_c   = 2'd2;
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase
    if (fresh) begin
      pend_d = PendIdle;
      if (in_i.byte_in == PctChar && !in_i.end_of_line) begin
        pend_d = PendPct;
      end else begin
        res_c[n_c].byte_out = in_i.byte_in;
        n_c = n_c + 2'd1;
      end
    end
    if (in_i.end_of_line) begin
      pend_d = PendIdle;
    end
    for (int k = 0; k < MaxRes; k++) begin
      res_c[k].last_of_run = (2'(k) + 2'd1 == n_c);
      res_c[k].line_done   = (2'(k) + 2'd1 == n_c) && in_i.end_of_line;
      widx[k]              = wr_q + FifoAw'(k);
    end
  end

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      count_d = count_d + FifoCw'(n_c);
    end
    if (out_xfer) begin
      count_d = count_d - FifoCw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      printable_q <= 1'b0;
      pend_q      <= PendIdle;
      held_q      <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_i.valid) begin
        printable_q <= cfg_i.printable_only;
      end
      if (in_xfer) begin
        pend_q <= pend_d;
        held_q <= held_d;
        wr_q   <= wr_q + FifoAw'(n_c);
      end
      if (out_xfer) begin
        rd_q <= rd_q + FifoAw'(1);
      end
      count_q <= count_d;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int k = 0; k < MaxRes; k++) begin
        if (2'(k) < n_c) begin
          fifo_q[widx[k]] <= res_c[k];
        end
      end
    end
  end

  assign out_o.valid       = (count_q != '0);
  assign out_o.byte_out    = fifo_q[rd_q].byte_out;
  assign out_o.last_of_run = fifo_q[rd_q].last_of_run;
  assign out_o.line_done   = fifo_q[rd_q].line_done;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCw'(FifoDepth))
    else $error("output queue overfilled");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.end_of_line |=> pend_q == PendIdle)
    else $error("escape state left pending at line end");

  a_eol_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.end_of_line |=> count_q != '0)
    else $error("line end transfer produced no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> count_q >= $past(count_q))
    else $error("queued result lost while stalled");

endmodule
